@@ sv/pid_speed_controller_unit_assert.svh @@
// Assertion macros used by the controller's top-level RTL file.
`ifndef PID_SPEED_CONTROLLER_UNIT_ASSERT_SVH
`define PID_SPEED_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIDSC_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("pidsc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PIDSC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("pidsc: next-cycle check failed");

`endif

@@ sv/pidsc_pkg.sv @@
package pidsc_pkg;

    localparam int FRACTION_BITS = 8;
    localparam int DATA_W        = 16;
    localparam int ACC_W         = DATA_W + FRACTION_BITS;
    localparam int DIFF_W        = DATA_W + 1;
    localparam int PROD_W        = DATA_W + DIFF_W;
    localparam int SUM_W         = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 3;
    localparam int TIME_W        = 32;

    localparam int APB_DATA_W = 32;
    localparam int REG_COUNT  = 8;
    localparam int REG_IDX_W  = $clog2(REG_COUNT);
    localparam int APB_ADDR_W = REG_IDX_W + 2;

    localparam logic [REG_IDX_W-1:0] REG_GAIN_P_ERROR    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_P_MEASURE  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_INTEGRAL   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_DERIVATIVE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT_LOW       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT_HIGH      = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_PERIOD   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_INVERT_OUTPUT   = 3'd7;

    localparam logic [DATA_W-1:0] RST_LIMIT_LOW     = 16'd10;
    localparam logic [DATA_W-1:0] RST_LIMIT_HIGH    = 16'd9990;
    localparam logic [DATA_W-1:0] RST_SAMPLE_PERIOD = 16'd100;
    localparam logic              RST_INVERT_OUTPUT = 1'b1;
    localparam logic [DATA_W-1:0] DRIVE_FULL_SCALE  = 16'd10000;

    typedef struct packed {
        logic signed [DATA_W-1:0] measurement;
        logic signed [DATA_W-1:0] target;
        logic [TIME_W-1:0]        now_ms;
        logic                     auto_mode;
    } sample_t;

    typedef struct packed {
        logic [DATA_W-1:0] drive_value;
        logic [DATA_W-1:0] control_output;
    } result_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] gain_p_error;
        logic signed [DATA_W-1:0] gain_p_measure;
        logic signed [DATA_W-1:0] gain_integral;
        logic signed [DATA_W-1:0] gain_derivative;
        logic [DATA_W-1:0]        limit_low;
        logic [DATA_W-1:0]        limit_high;
        logic [DATA_W-1:0]        sample_period;
        logic                     invert_output;
    } cfg_t;

    typedef struct packed {
        logic [ACC_W-1:0]         integral_sum;
        logic signed [DATA_W-1:0] prev_meas;
        logic [DATA_W-1:0]        prev_output;
        logic [TIME_W-1:0]        prev_time;
        logic                     auto_active;
        logic                     first_pending;
    } state_t;

    typedef struct packed {
        logic              rising;
        logic              compute;
        logic [ACC_W-1:0]  bump_integral;
        logic [ACC_W-1:0]  new_integral;
        logic [DATA_W-1:0] ctl;
        logic [DATA_W-1:0] drive;
    } calc_t;

    // Upper limit is tested first, so crossed limits give one of the two limits.
    function automatic logic [ACC_W-1:0] clamp_limits(
        input logic signed [SUM_W-1:0] v,
        input logic [DATA_W-1:0]       lo,
        input logic [DATA_W-1:0]       hi
    );
        logic signed [SUM_W-1:0] hi_s;
        logic signed [SUM_W-1:0] lo_s;
        logic [ACC_W-1:0]        res;
        hi_s = $signed({{(SUM_W-ACC_W){1'b0}}, hi, {FRACTION_BITS{1'b0}}});
        lo_s = $signed({{(SUM_W-ACC_W){1'b0}}, lo, {FRACTION_BITS{1'b0}}});
        if (v > hi_s)
        begin
            res = hi_s[ACC_W-1:0];
        end
        else if (v < lo_s)
        begin
            res = lo_s[ACC_W-1:0];
        end
        else
        begin
            res = v[ACC_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ sv/pid_speed_controller_unit.sv @@
// PID speed controller, proportional on error and on measurement, fixed point.
// Sample requests (measurement, target, now_ms, auto_mode) enter on the
// sample channel; each request that computes gives one result request
// (drive_value, control_output) on the result channel, others give none.
// Gains, limits, sample period and inversion sit in APB registers at 4*index;
// write them only while no request is in flight.
// An accepted request is registered in the input register, processed in the
// stage that follows and its result lands in the result register. Throughput
// is one request per cycle while the result register has room: the four gain
// products, the integral add-and-clamp and the output add-and-clamp all sit in
// the single stage between the input register and the result register, which
// also updates the integral feedback for every retired request.
// When the result receiver stalls, a waiting result holds; the stage behind it
// still retires requests that give no result, and sample_ready drops only
// when a computing request finds the result register full.
// Reset clears both valid flags, the controller state (integral, last
// measurement, last output, last time, auto flag) and sets the first-sample
// flag, so the first automatic request after reset always computes; the
// configuration registers return to their documented defaults.
`include "pid_speed_controller_unit_assert.svh"

module pid_speed_controller_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pidsc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pidsc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pidsc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready,
    input  logic                               sample_valid,
    output logic                               sample_ready,
    input  pidsc_pkg::sample_t                 sample,
    output logic                               result_valid,
    input  logic                               result_ready,
    output pidsc_pkg::result_t                 result
);
    import pidsc_pkg::*;

    cfg_t    cfg;
    calc_t   calc;
    sample_t s1_reg;
    logic    s1_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_reg;
    logic    result_valid_reg;
    logic    out_free;
    logic    s1_fire;

    pidsc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pidsc_calc u_calc (
        .sample (s1_reg),
        .cfg    (cfg),
        .state  (state_reg),
        .calc   (calc)
    );

    // The stage retires its request unless it has a result and nowhere to put it.
    assign out_free     = !result_valid_reg || result_ready;
    assign s1_fire      = s1_valid_reg && (!calc.compute || out_free);
    assign sample_ready = !s1_valid_reg || s1_fire;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Controller state follows every retired request, not only computing ones.
    always_comb
    begin
        state_next = state_reg;
        if (s1_fire)
        begin
            state_next.auto_active = s1_reg.auto_mode;
            if (calc.rising)
            begin
                state_next.prev_meas    = s1_reg.measurement;
                state_next.integral_sum = calc.bump_integral;
            end
            if (calc.compute)
            begin
                state_next.integral_sum  = calc.new_integral;
                state_next.prev_meas     = s1_reg.measurement;
                state_next.prev_output   = calc.ctl;
                state_next.prev_time     = s1_reg.now_ms;
                state_next.first_pending = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg            <= 1'b0;
            result_valid_reg        <= 1'b0;
            state_reg.integral_sum  <= '0;
            state_reg.prev_meas     <= '0;
            state_reg.prev_output   <= '0;
            state_reg.prev_time     <= '0;
            state_reg.auto_active   <= 1'b0;
            state_reg.first_pending <= 1'b1;
        end
        else
        begin
            if (sample_ready)
            begin
                s1_valid_reg <= sample_valid;
            end
            if (s1_fire && calc.compute)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            s1_reg <= sample;
        end
        if (s1_fire && calc.compute)
        begin
            result_reg.drive_value    <= calc.drive;
            result_reg.control_output <= calc.ctl;
        end
    end

    // Once the first computation has happened the flag never returns.
    `PIDSC_ASSERT_NEXT(a_first_once, clk, rst_n, !state_reg.first_pending,
                       !state_reg.first_pending)

    // A manual-mode request never produces a result.
    `PIDSC_ASSERT_IMPL(a_manual_silent, clk, rst_n,
                       s1_valid_reg && !s1_reg.auto_mode, !calc.compute)

    // With ordered limits, a new output lies between them.
    `PIDSC_ASSERT_NEXT(a_output_in_limits, clk, rst_n,
                       s1_fire && calc.compute && (cfg.limit_low <= cfg.limit_high),
                       (result_reg.control_output >= $past(cfg.limit_low)) &&
                       (result_reg.control_output <= $past(cfg.limit_high)))

    // The last-computation time moves only together with a fresh result.
    `PIDSC_ASSERT_IMPL(a_time_with_result, clk, rst_n,
                       !$stable(state_reg.prev_time), result_valid_reg)

endmodule

@@ sv/pidsc_apb_regs.sv @@
module pidsc_apb_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pidsc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pidsc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pidsc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready,
    output pidsc_pkg::cfg_t                    cfg
);
    import pidsc_pkg::*;

    cfg_t                 cfg_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p_error    <= '0;
            cfg_reg.gain_p_measure  <= '0;
            cfg_reg.gain_integral   <= '0;
            cfg_reg.gain_derivative <= '0;
            cfg_reg.limit_low       <= RST_LIMIT_LOW;
            cfg_reg.limit_high      <= RST_LIMIT_HIGH;
            cfg_reg.sample_period   <= RST_SAMPLE_PERIOD;
            cfg_reg.invert_output   <= RST_INVERT_OUTPUT;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_GAIN_P_ERROR:    cfg_reg.gain_p_error    <= $signed(pwdata[DATA_W-1:0]);
                REG_GAIN_P_MEASURE:  cfg_reg.gain_p_measure  <= $signed(pwdata[DATA_W-1:0]);
                REG_GAIN_INTEGRAL:   cfg_reg.gain_integral   <= $signed(pwdata[DATA_W-1:0]);
                REG_GAIN_DERIVATIVE: cfg_reg.gain_derivative <= $signed(pwdata[DATA_W-1:0]);
                REG_LIMIT_LOW:       cfg_reg.limit_low       <= pwdata[DATA_W-1:0];
                REG_LIMIT_HIGH:      cfg_reg.limit_high      <= pwdata[DATA_W-1:0];
                REG_SAMPLE_PERIOD:   cfg_reg.sample_period   <= pwdata[DATA_W-1:0];
                REG_INVERT_OUTPUT:   cfg_reg.invert_output   <= pwdata[0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Gains read back sign-extended, the other registers zero-extended.
    always_comb
    begin
        case (reg_idx)
            REG_GAIN_P_ERROR:    prdata = APB_DATA_W'(cfg_reg.gain_p_error);
            REG_GAIN_P_MEASURE:  prdata = APB_DATA_W'(cfg_reg.gain_p_measure);
            REG_GAIN_INTEGRAL:   prdata = APB_DATA_W'(cfg_reg.gain_integral);
            REG_GAIN_DERIVATIVE: prdata = APB_DATA_W'(cfg_reg.gain_derivative);
            REG_LIMIT_LOW:       prdata = {{(APB_DATA_W-DATA_W){1'b0}}, cfg_reg.limit_low};
            REG_LIMIT_HIGH:      prdata = {{(APB_DATA_W-DATA_W){1'b0}}, cfg_reg.limit_high};
            REG_SAMPLE_PERIOD:   prdata = {{(APB_DATA_W-DATA_W){1'b0}}, cfg_reg.sample_period};
            REG_INVERT_OUTPUT:   prdata = {{(APB_DATA_W-1){1'b0}}, cfg_reg.invert_output};
            default:             prdata = '0;
        endcase
    end

endmodule

@@ sv/pidsc_calc.sv @@
module pidsc_calc (
    input  pidsc_pkg::sample_t sample,
    input  pidsc_pkg::cfg_t    cfg,
    input  pidsc_pkg::state_t  state,
    output pidsc_pkg::calc_t   calc
);
    import pidsc_pkg::*;

    logic                     rising;
    logic [TIME_W-1:0]        elapsed;
    logic                     due;
    logic signed [DATA_W-1:0] base_meas;
    logic [ACC_W-1:0]         bump;
    logic [ACC_W-1:0]         base_integral;
    logic signed [DIFF_W-1:0] error;
    logic signed [DIFF_W-1:0] dmeas;
    logic signed [PROD_W-1:0] prod_i;
    logic signed [PROD_W-1:0] prod_m;
    logic signed [PROD_W-1:0] prod_e;
    logic signed [PROD_W-1:0] prod_d;
    logic signed [SUM_W-1:0]  acc_sum;
    logic signed [SUM_W-1:0]  out_sum;
    logic [ACC_W-1:0]         acc_clamped;
    logic [ACC_W-1:0]         out_clamped;
    logic [DATA_W-1:0]        ctl;

    // A rising auto flag restarts from the last output and current measurement.
    assign rising        = sample.auto_mode && !state.auto_active;
    assign bump          = clamp_limits(
                               $signed({{(SUM_W-ACC_W){1'b0}}, state.prev_output,
                                        {FRACTION_BITS{1'b0}}}),
                               cfg.limit_low, cfg.limit_high);
    assign base_integral = rising ? bump : state.integral_sum;
    assign base_meas     = rising ? sample.measurement : state.prev_meas;

    assign elapsed = sample.now_ms - state.prev_time;
    assign due     = state.first_pending ||
                     (elapsed >= {{(TIME_W-DATA_W){1'b0}}, cfg.sample_period});

    assign error = $signed({sample.target[DATA_W-1], sample.target})
                 - $signed({sample.measurement[DATA_W-1], sample.measurement});
    assign dmeas = $signed({sample.measurement[DATA_W-1], sample.measurement})
                 - $signed({base_meas[DATA_W-1], base_meas});

    // A zero gain gives a zero product, so no separate disable is needed.
    assign prod_i = cfg.gain_integral   * error;
    assign prod_m = cfg.gain_p_measure  * dmeas;
    assign prod_e = cfg.gain_p_error    * error;
    assign prod_d = cfg.gain_derivative * dmeas;

    assign acc_sum     = $signed({{(SUM_W-ACC_W){1'b0}}, base_integral})
                       + SUM_W'(prod_i) - SUM_W'(prod_m);
    assign acc_clamped = clamp_limits(acc_sum, cfg.limit_low, cfg.limit_high);

    assign out_sum     = $signed({{(SUM_W-ACC_W){1'b0}}, acc_clamped})
                       + SUM_W'(prod_e) - SUM_W'(prod_d);
    assign out_clamped = clamp_limits(out_sum, cfg.limit_low, cfg.limit_high);
    assign ctl         = out_clamped[ACC_W-1:FRACTION_BITS];

    always_comb
    begin
        calc.rising        = rising;
        calc.compute       = sample.auto_mode && due;
        calc.bump_integral = bump;
        calc.new_integral  = acc_clamped;
        calc.ctl           = ctl;
        if (!cfg.invert_output)
        begin
            calc.drive = ctl;
        end
        else if (ctl >= DRIVE_FULL_SCALE)
        begin
            calc.drive = '0;
        end
        else
        begin
            calc.drive = DRIVE_FULL_SCALE - ctl;
        end
    end

endmodule

@@ tb/pid_speed_controller_unit_tb.sv @@
module pid_speed_controller_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pidsc_pkg::*;

    // Cycles allowed after the last awaited output before the block is
    // treated as idle. A request that gives no output leaves no trace to wait
    // for, so these cycles give the block time to retire it.
    localparam int SETTLE_CYCLES = 4;
    // The random part is split into blocks, each run under its own settings.
    localparam int BLOCK_COUNT = 6;
    // Automatic-mode requests per block; manual requests come on top.
    localparam int BLOCK_ITEMS = 100;
    // Hard stop for the whole run, in ns.
    localparam longint RUN_LIMIT_NS = 5_000_000;

    // Kinds of row in the directed table. A register write is done only once
    // the block has gone quiet; a sample row carries either a typed-in
    // output, a typed-in "no output", or is left to the controller model.
    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_NONE,
        ROW_VALUE,
        ROW_PREDICT
    } row_kind_e;

    typedef struct packed {
        row_kind_e              kind;
        logic [REG_IDX_W-1:0]   reg_idx;
        logic [APB_DATA_W-1:0]  reg_value;
        sample_t                smp;
        result_t                typed;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  sample_valid = 1'b0;
    logic                  sample_ready;
    sample_t               sample = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_t               result;

    pid_speed_controller_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #4 clk = ~clk;

    // The testbench's own copy of the register file and of the loop state.
    // The integral is held with FRACTION_BITS fraction bits, like the block.
    cfg_t        reg_mirror;
    longint      integ_acc;
    longint      last_meas;
    logic [15:0] last_ctl;
    logic [31:0] last_stamp;
    logic        loop_auto;
    logic        awaiting_first;

    // Outputs still owed by the block, oldest first.
    result_t     awaited_outputs[$];
    stim_row_t   directed_rows[$];

    int          mismatch_count = 0;
    int          requests_sent = 0;
    int          outputs_checked = 0;
    int          register_writes = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic [31:0] stamp_track = '0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // The upper limit is tested first, so crossed limits always give one of
    // the two limits and never the value itself.
    function automatic longint clamp_to_limits(input longint v);
        longint hi;
        longint lo;
        hi = longint'(reg_mirror.limit_high) << FRACTION_BITS;
        lo = longint'(reg_mirror.limit_low) << FRACTION_BITS;
        if (v > hi)
        begin
            return hi;
        end
        if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

    function automatic void reset_loop_model();
        reg_mirror = '0;
        reg_mirror.limit_low = RST_LIMIT_LOW;
        reg_mirror.limit_high = RST_LIMIT_HIGH;
        reg_mirror.sample_period = RST_SAMPLE_PERIOD;
        reg_mirror.invert_output = RST_INVERT_OUTPUT;
        integ_acc = 0;
        last_meas = 0;
        last_ctl = '0;
        last_stamp = '0;
        loop_auto = 1'b0;
        awaiting_first = 1'b1;
    endfunction

    function automatic void mirror_register_write(input logic [REG_IDX_W-1:0] idx,
                                                  input logic [APB_DATA_W-1:0] value);
        case (idx)
            REG_GAIN_P_ERROR:    reg_mirror.gain_p_error = value[15:0];
            REG_GAIN_P_MEASURE:  reg_mirror.gain_p_measure = value[15:0];
            REG_GAIN_INTEGRAL:   reg_mirror.gain_integral = value[15:0];
            REG_GAIN_DERIVATIVE: reg_mirror.gain_derivative = value[15:0];
            REG_LIMIT_LOW:       reg_mirror.limit_low = value[15:0];
            REG_LIMIT_HIGH:      reg_mirror.limit_high = value[15:0];
            REG_SAMPLE_PERIOD:   reg_mirror.sample_period = value[15:0];
            REG_INVERT_OUTPUT:   reg_mirror.invert_output = value[0];
            default:             ;
        endcase
    endfunction

    // Advances the loop model by one accepted request. Returns 1 and fills
    // ctl_out when the request computes, 0 when it gives no output.
    function automatic bit compute_control_step(input sample_t s, output result_t ctl_out);
        longint      meas;
        longint      tgt;
        longint      err;
        longint      dmeas;
        longint      acc;
        longint      outv;
        longint      k_pe;
        longint      k_pm;
        longint      k_i;
        longint      k_d;
        logic [31:0] elapsed;
        logic [15:0] ctl;
        ctl_out = '0;
        meas = longint'($signed(s.measurement));
        tgt = longint'($signed(s.target));
        k_pe = longint'($signed(reg_mirror.gain_p_error));
        k_pm = longint'($signed(reg_mirror.gain_p_measure));
        k_i = longint'($signed(reg_mirror.gain_integral));
        k_d = longint'($signed(reg_mirror.gain_derivative));

        // Bumpless start: a rising auto flag picks up from the last output.
        if (s.auto_mode && !loop_auto)
        begin
            last_meas = meas;
            integ_acc = clamp_to_limits(longint'(last_ctl) << FRACTION_BITS);
        end
        loop_auto = s.auto_mode;
        if (!loop_auto)
        begin
            return 0;
        end

        // Elapsed time is taken modulo 2^32 and compared unsigned.
        elapsed = s.now_ms - last_stamp;
        if (!awaiting_first && (elapsed < {16'd0, reg_mirror.sample_period}))
        begin
            return 0;
        end

        err = tgt - meas;
        dmeas = meas - last_meas;

        acc = integ_acc + k_i * err;
        if (k_pm != 0)
        begin
            acc = acc - k_pm * dmeas;
        end
        acc = clamp_to_limits(acc);
        integ_acc = acc;

        outv = (k_pe != 0) ? k_pe * err : 0;
        outv = clamp_to_limits(outv + acc - k_d * dmeas);
        ctl = outv[FRACTION_BITS +: 16];

        if (reg_mirror.invert_output)
        begin
            ctl_out.drive_value = (ctl >= DRIVE_FULL_SCALE) ? 16'd0 : DRIVE_FULL_SCALE - ctl;
        end
        else
        begin
            ctl_out.drive_value = ctl;
        end
        ctl_out.control_output = ctl;

        last_ctl = ctl;
        last_meas = meas;
        last_stamp = s.now_ms;
        awaiting_first = 1'b0;
        return 1;
    endfunction

    function automatic stim_row_t write_row(input logic [REG_IDX_W-1:0] idx,
                                            input logic [APB_DATA_W-1:0] value);
        stim_row_t row;
        row = '0;
        row.kind = ROW_WRITE;
        row.reg_idx = idx;
        row.reg_value = value;
        return row;
    endfunction

    function automatic stim_row_t sample_row(input row_kind_e kind, input int meas,
                                             input int tgt, input logic [31:0] stamp,
                                             input logic auto_on, input int drive,
                                             input int ctl);
        stim_row_t row;
        row = '0;
        row.kind = kind;
        row.smp.measurement = meas[15:0];
        row.smp.target = tgt[15:0];
        row.smp.now_ms = stamp;
        row.smp.auto_mode = auto_on;
        row.typed.drive_value = drive[15:0];
        row.typed.control_output = ctl[15:0];
        return row;
    endfunction

    // Presents one sample request, holds it until it is taken, then books
    // the output it owes (typed in, or worked out by the loop model).
    task automatic present_sample(input sample_t s, input row_kind_e kind,
                                  input result_t typed);
        result_t predicted;
        bit      fires;
        while ($urandom_range(1, 100) <= send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (!sample_ready)
        begin
            @(posedge clk);
        end
        requests_sent++;
        fires = compute_control_step(s, predicted);
        if (kind == ROW_VALUE)
        begin
            awaited_outputs.push_back(typed);
        end
        else if ((kind == ROW_PREDICT) && fires)
        begin
            awaited_outputs.push_back(predicted);
        end
    endtask

    // Stops sending and waits for every owed output, then gives any request
    // that owes nothing time to leave the pipeline.
    task automatic drain_and_settle();
        sample_valid <= 1'b0;
        while (awaited_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, access cycle, then a wait with psel low so that a
    // following write never lowers and raises psel in the same time step.
    task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        mirror_register_write(idx, value);
        register_writes++;
        @(posedge clk);
    endtask

    // Gains are mostly small so that the loop spends time inside its limits;
    // zero (term disabled) and full-range values turn up as well.
    function automatic logic [15:0] pick_gain();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0)
        begin
            return 16'd0;
        end
        if (roll == 1)
        begin
            return 16'($urandom());
        end
        return 16'(int'($urandom_range(0, 1024)) - 512);
    endfunction

    task automatic randomise_settings();
        int roll;
        int lo;
        int hi;
        int period;
        roll = $urandom_range(0, 9);
        if (roll == 0)
        begin
            // Crossed limits.
            lo = $urandom_range(2000, 65535);
            hi = $urandom_range(0, lo - 1);
        end
        else if (roll == 1)
        begin
            lo = 0;
            hi = 65535;
        end
        else
        begin
            lo = $urandom_range(0, 3000);
            hi = lo + int'($urandom_range(0, 12000));
        end
        roll = $urandom_range(0, 9);
        period = (roll == 0) ? 0 : (roll == 1) ? 65535 : int'($urandom_range(1, 300));

        write_register(REG_GAIN_P_ERROR, {16'd0, pick_gain()});
        write_register(REG_GAIN_P_MEASURE, {16'd0, pick_gain()});
        write_register(REG_GAIN_INTEGRAL, {16'd0, pick_gain()});
        write_register(REG_GAIN_DERIVATIVE, {16'd0, pick_gain()});
        write_register(REG_LIMIT_LOW, 32'(lo));
        write_register(REG_LIMIT_HIGH, 32'(hi));
        write_register(REG_SAMPLE_PERIOD, 32'(period));
        write_register(REG_INVERT_OUTPUT, 32'($urandom_range(0, 1)));
    endtask

    // Output side: takes result requests with random stalls, and compares
    // each one with the oldest owed output, field by field.
    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
            begin
                if (awaited_outputs.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result drive=%0d ctl=%0d",
                                              result.drive_value, result.control_output));
                end
                else
                begin
                    want = awaited_outputs.pop_front();
                    outputs_checked++;
                    if (result.drive_value !== want.drive_value)
                    begin
                        report_mismatch($sformatf("drive_value %0d, expected %0d",
                                                  result.drive_value, want.drive_value));
                    end
                    if (result.control_output !== want.control_output)
                    begin
                        report_mismatch($sformatf("control_output %0d, expected %0d",
                                                  result.control_output,
                                                  want.control_output));
                    end
                end
            end
            result_ready <= ($urandom_range(1, 100) > recv_idle_pct);
        end
    end

    // Overall watchdog.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("pid_speed_controller_unit verification failed");
        $finish;
    end

    initial
    begin
        sample_t s;
        int      counted;
        int      pick;
        int      tgt_i;
        int      meas_i;
        bit      pressure_done;

        reset_loop_model();
        pressure_done = 1'b0;

        // Directed table. Before any write the gains are zero and the limits
        // are 10 and 9990, so the loop simply sits on its lower limit and the
        // inverted drive is 9990: those outputs are typed in. Next come the
        // extreme gains with full-scale inputs, the timestamp wrap, manual
        // hold and the bumpless start, crossed limits, a zero sample period
        // (every automatic request computes), and the full output range with
        // inversion saturating at zero.
        directed_rows = '{
            sample_row(ROW_NONE,    32767, -32768, 32'h0000_0000, 1'b0, 0, 0),
            sample_row(ROW_VALUE,  -32768,  32767, 32'h0000_0000, 1'b1, 9990, 10),
            sample_row(ROW_NONE,        0,      0, 32'h0000_0063, 1'b1, 0, 0),
            sample_row(ROW_VALUE,       0,      0, 32'h0000_0064, 1'b1, 9990, 10),
            write_row(REG_GAIN_INTEGRAL,   32'h0000_7FFF),
            write_row(REG_GAIN_P_ERROR,    32'h0000_8000),
            write_row(REG_GAIN_P_MEASURE,  32'h0000_7FFF),
            write_row(REG_GAIN_DERIVATIVE, 32'h0000_8000),
            sample_row(ROW_PREDICT, 32767, -32768, 32'hFFFF_FFFF, 1'b1, 0, 0),
            sample_row(ROW_PREDICT, -32768, 32767, 32'h0000_0063, 1'b1, 0, 0),
            sample_row(ROW_NONE,        0,      0, 32'h0000_00C6, 1'b1, 0, 0),
            sample_row(ROW_NONE,      100,    200, 32'h0000_1000, 1'b0, 0, 0),
            sample_row(ROW_PREDICT,  1000,   1200, 32'h0000_1000, 1'b1, 0, 0),
            write_row(REG_LIMIT_LOW,       32'h0000_FFFF),
            write_row(REG_LIMIT_HIGH,      32'h0000_0000),
            sample_row(ROW_PREDICT,     5,      6, 32'h0000_2000, 1'b1, 0, 0),
            write_row(REG_SAMPLE_PERIOD,   32'h0000_0000),
            write_row(REG_INVERT_OUTPUT,   32'h0000_0000),
            sample_row(ROW_PREDICT,    -5,     -6, 32'h0000_2000, 1'b1, 0, 0),
            sample_row(ROW_PREDICT,     0,      0, 32'h0000_2000, 1'b1, 0, 0),
            write_row(REG_LIMIT_LOW,       32'h0000_0000),
            write_row(REG_LIMIT_HIGH,      32'h0000_FFFF),
            write_row(REG_INVERT_OUTPUT,   32'h0000_0001),
            sample_row(ROW_PREDICT, -32768, 32767, 32'h0000_2000, 1'b1, 0, 0),
            write_row(REG_SAMPLE_PERIOD,   32'h0000_FFFF),
            sample_row(ROW_NONE,        0,      0, 32'h0001_1FFE, 1'b1, 0, 0),
            sample_row(ROW_PREDICT, 32767, -32768, 32'h0001_1FFF, 1'b1, 0, 0)
        };

        send_idle_pct = 34;
        recv_idle_pct = 71;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                drain_and_settle();
                write_register(directed_rows[i].reg_idx, directed_rows[i].reg_value);
            end
            else
            begin
                present_sample(directed_rows[i].smp, directed_rows[i].kind,
                               directed_rows[i].typed);
            end
        end
        stamp_track = 32'h0002_0000;

        // Random part. The first third has a lazy sender and a busy receiver,
        // the second the other way round, the last runs flat out. Most
        // requests are automatic with a timestamp that creeps forward by up
        // to twice the sample period plus one, so roughly half of them compute; the
        // rest are manual holds (which also set up bumpless starts) and
        // requests with a wild timestamp.
        for (int blk = 0; blk < BLOCK_COUNT; blk++)
        begin
            case (blk / 2)
                0:
                begin
                    send_idle_pct = 34;
                    recv_idle_pct = 71;
                end
                1:
                begin
                    send_idle_pct = 71;
                    recv_idle_pct = 34;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            drain_and_settle();
            randomise_settings();
            if ($urandom_range(0, 3) == 0)
            begin
                // Start close to the top so the timestamp wraps in this block.
                stamp_track = 32'hFFFF_FFFF - 32'($urandom_range(0, 2000));
            end

            counted = 0;
            while (counted < BLOCK_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 9) == 0)
                begin
                    s.target = 16'($urandom());
                end
                else
                begin
                    tgt_i = int'($urandom_range(0, 6000)) - 3000;
                    s.target = tgt_i[15:0];
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    s.measurement = 16'($urandom());
                end
                else
                begin
                    meas_i = int'($signed(s.target)) + int'($urandom_range(0, 400)) - 200;
                    s.measurement = meas_i[15:0];
                end
                if ((pick >= 8) && (pick < 14))
                begin
                    stamp_track = $urandom();
                end
                else
                begin
                    stamp_track = stamp_track
                                  + 32'($urandom_range(0, 2 * reg_mirror.sample_period + 1));
                end
                s.now_ms = stamp_track;
                s.auto_mode = (pick >= 8);

                present_sample(s, ROW_PREDICT, '0);
                if (s.auto_mode)
                begin
                    counted++;
                end

                // Once, halfway through a block, the sender holds off until
                // every owed output has come back.
                if ((blk == 2) && (counted == BLOCK_ITEMS / 2) && !pressure_done)
                begin
                    drain_and_settle();
                    pressure_done = 1'b1;
                end
            end
        end

        drain_and_settle();

        $display("Run covered %0d sample requests and %0d checked outputs over %0d register writes,",
                 requests_sent, outputs_checked, register_writes);
        $display("including crossed limits, zero and full sample periods and timestamp wrap.");
        if (mismatch_count == 0)
        begin
            $display("pid_speed_controller_unit verification clean");
        end
        else
        begin
            $display("pid_speed_controller_unit verification failed");
        end
        $finish;
    end

endmodule
